### rtl/core/evhp_pkg.sv
// ----------------------------------------------------------------------------
// evhp_pkg
// Types and constants shared by the Ethernet/VLAN header parser modules.
// ----------------------------------------------------------------------------
package evhp_pkg;

  // Width of the per-frame byte counter; it saturates at its all-ones value.
  localparam int unsigned CountWidth = 11;
  localparam int unsigned CfgWidth   = 11;
  // Width used when comparing the count with the configured minimum.
  localparam int unsigned CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CountWidth-1:0] DstEnd    = CountWidth'(6);
  localparam logic [CountWidth-1:0] SrcEnd    = CountWidth'(12);
  localparam logic [CountWidth-1:0] TypeEnd   = CountWidth'(14);
  localparam logic [CountWidth-1:0] TagEnd    = CountWidth'(16);
  localparam logic [CountWidth-1:0] InnerEnd  = CountWidth'(18);

  localparam logic [CfgWidth-1:0]   MinLenReset = CfgWidth'(14);

  localparam logic [15:0] TpidCtag = 16'h8100;
  localparam logic [15:0] TpidStag = 16'h88A8;

  localparam logic [4:0] HdrLenBase   = 5'd14;
  localparam logic [4:0] HdrLenTagged = 5'd18;

  localparam int unsigned PcpShift = 13;
  localparam logic [15:0] PcpMask  = 16'h0007;
  localparam logic [15:0] VidMask  = 16'h0FFF;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TOO_SHORT   = 2'd1,
    STATUS_TRUNC_TAG   = 2'd2,
    STATUS_TRUNC_INNER = 2'd3
  } evhp_status_e;

  // Frame state as it stands after the byte being accepted.
  typedef struct packed {
    logic [CountWidth-1:0] len;
    logic [47:0]           dst_mac;
    logic [47:0]           src_mac;
    logic [15:0]           outer_type;
    logic [15:0]           tag_control;
    logic [15:0]           inner_type;
  } evhp_frame_t;

  typedef struct packed {
    evhp_status_e status;
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [15:0]  ethertype;
    logic         has_tag;
    logic [15:0]  tag_tpid;
    logic [2:0]   tag_prio;
    logic [11:0]  tag_vid;
    logic [4:0]   header_len;
  } evhp_result_t;

endpackage

### rtl/core/evhp_capture.sv
// ----------------------------------------------------------------------------
// evhp_capture
// Byte counter and header field capture registers for one frame.
// ----------------------------------------------------------------------------
module evhp_capture (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output evhp_pkg::evhp_frame_t frame_o
);
  import evhp_pkg::*;

  evhp_frame_t state_q;
  evhp_frame_t frame_d;
  evhp_frame_t state_d;

  always_comb begin
    frame_d = state_q;
    priority if (state_q.len < DstEnd) begin
      frame_d.dst_mac = {state_q.dst_mac[39:0], data_byte_i};
    end else if (state_q.len < SrcEnd) begin
      frame_d.src_mac = {state_q.src_mac[39:0], data_byte_i};
    end else if (state_q.len < TypeEnd) begin
      frame_d.outer_type = {state_q.outer_type[7:0], data_byte_i};
    end else if (state_q.len < TagEnd) begin
      frame_d.tag_control = {state_q.tag_control[7:0], data_byte_i};
    end else if (state_q.len < InnerEnd) begin
      frame_d.inner_type = {state_q.inner_type[7:0], data_byte_i};
    end else begin
      frame_d = state_q;
    end
    // The length saturates so that very long frames still report as long.
    if (state_q.len != CountMax) begin
      frame_d.len = state_q.len + CountWidth'(1);
    end
  end

  // The state is cleared once the final byte of a frame has been taken.
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      if (last_byte_i) begin
        state_d = '0;
      end else begin
        state_d = frame_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign frame_o = frame_d;

endmodule

### rtl/core/evhp_result.sv
// ----------------------------------------------------------------------------
// evhp_result
// Frame checks, result formatting, and the output register with skid slot.
// ----------------------------------------------------------------------------
module evhp_result (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  evhp_pkg::evhp_frame_t frame_i,
  input  logic [evhp_pkg::CfgWidth-1:0] min_len_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output evhp_pkg::evhp_result_t out_o
);
  import evhp_pkg::*;

  evhp_result_t res;
  evhp_status_e status;
  logic         tag_seen;
  logic [CmpWidth-1:0] len_ext;
  logic [CmpWidth-1:0] min_ext;

  evhp_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign len_ext  = CmpWidth'(frame_i.len);
  assign min_ext  = CmpWidth'(min_len_i);
  assign tag_seen = (frame_i.outer_type == TpidCtag) || (frame_i.outer_type == TpidStag);

  always_comb begin
    priority if ((len_ext < min_ext) || (frame_i.len < TypeEnd)) begin
      status = STATUS_TOO_SHORT;
    end else if (tag_seen && (frame_i.len < TagEnd)) begin
      status = STATUS_TRUNC_TAG;
    end else if (tag_seen && (frame_i.len < InnerEnd)) begin
      status = STATUS_TRUNC_INNER;
    end else begin
      status = STATUS_OK;
    end
  end

  // On any error only the status is reported; every other field stays zero.
  always_comb begin
    res        = '0;
    res.status = status;
    if (status == STATUS_OK) begin
      res.dst_mac = frame_i.dst_mac;
      res.src_mac = frame_i.src_mac;
      if (tag_seen) begin
        res.ethertype  = frame_i.inner_type;
        res.has_tag    = 1'b1;
        res.tag_tpid   = frame_i.outer_type;
        res.tag_prio   = 3'((frame_i.tag_control >> PcpShift) & PcpMask);
        res.tag_vid    = 12'(frame_i.tag_control & VidMask);
        res.header_len = HdrLenTagged;
      end else begin
        res.ethertype  = frame_i.outer_type;
        res.header_len = HdrLenBase;
      end
    end
  end

  // A new result goes to the output register unless that register holds a
  // result which is not being taken this cycle; then it waits in the skid slot.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/core/ethernet_vlan_header_parser_core.sv
// ----------------------------------------------------------------------------
// ethernet_vlan_header_parser_core
// Ethernet header parser with a single 802.1Q / 802.1ad tag.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle while s_axis_tready_o is high and
// gives one result for every byte marked last, from the output register.
// The sustained rate is one byte per clock under that condition. A second
// result can wait in a skid slot behind the output register, and
// s_axis_tready_o falls only while both are occupied. The user must write
// the minimum frame length register only while no frame is in progress; the
// block does not enforce this. A write takes effect for the next frame.
module ethernet_vlan_header_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [evhp_pkg::CfgWidth-1:0] cfg_wdata_i,   // minimum frame length
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,                 // data_byte
  input  logic         s_axis_tlast_i,                 // last_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // dst_mac, src_mac, ethertype, has_tag, tag_tpid, tag_prio, tag_vid,
  // header_len, zero fill
  output logic [151:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o                  // status
);
  import evhp_pkg::*;

  logic [CfgWidth-1:0] min_len_q;
  logic         accept;
  logic         full;
  evhp_frame_t  frame;
  evhp_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  evhp_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .frame_o     (frame)
  );

  evhp_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept && s_axis_tlast_i),
    .frame_i         (frame),
    .min_len_i       (min_len_q),
    .full_o          (full),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_o           (res)
  );

  assign m_axis_tdata_o = {3'b000, res.header_len, res.tag_vid, res.tag_prio,
                           res.tag_tpid, res.has_tag, res.ethertype,
                           res.src_mac, res.dst_mac};
  assign m_axis_tuser_o = res.status;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ethernet/VLAN header parser core.
// ----------------------------------------------------------------------------
// Frames are streamed into the parser one byte per transaction. An in-bench
// header predictor follows every accepted byte and queues the header it
// expects for each frame end. Results are compared field by field in order.
// A table of directed frames covers the length boundaries, both tag
// protocol ids and the error codes. Random frames then follow at several
// minimum frame lengths, under varied back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import evhp_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    logic [11:0]  len;
    logic [15:0]  outer;
    logic [15:0]  tci;
    logic [15:0]  inner;
    logic [47:0]  dst;
    logic [47:0]  src;
    logic         typed;
    evhp_status_e status;
  } frame_row_t;

  typedef struct packed {
    logic         typed;
    evhp_status_e status;
  } frame_mark_t;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_data    = '0;
  logic                s_last    = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_tready  = 1'b0;
  logic [151:0]        m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  // Predictor state: a copy of the parser's per-frame capture registers.
  logic [CountWidth-1:0] byte_total = '0;
  logic [47:0]           dst_acc   = '0;
  logic [47:0]           src_acc   = '0;
  logic [15:0]           type_acc  = '0;
  logic [15:0]           tci_acc   = '0;
  logic [15:0]           inner_acc = '0;
  logic [CfgWidth-1:0]   min_len   = MinLenReset;

  evhp_result_t pending_headers[$];
  frame_mark_t  frame_marks[$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned sender_idle   = 0;
  int unsigned receiver_idle = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  // Error rows carry their status by hand; on an error every other field
  // is zero, so the whole header is known at a glance.
  frame_row_t dir_rows[14] = '{
    '{12'd1,    16'h0800, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TOO_SHORT},
    '{12'd13,   16'h8100, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TOO_SHORT},
    '{12'd14,   16'h0800, 16'h0000, 16'h0000, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, STATUS_OK},
    '{12'd14,   16'h8100, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TRUNC_TAG},
    '{12'd15,   16'h88A8, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TRUNC_TAG},
    '{12'd16,   16'h8100, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TRUNC_INNER},
    '{12'd17,   16'h88A8, 16'h0000, 16'h0000, 48'h0, 48'h0, 1'b1, STATUS_TRUNC_INNER},
    '{12'd18,   16'h8100, 16'hFFFF, 16'hFFFF, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, STATUS_OK},
    '{12'd18,   16'h88A8, 16'h0000, 16'h0000, 48'hFFFF_FFFF_FFFF,
      48'hFFFF_FFFF_FFFF, 1'b0, STATUS_OK},
    '{12'd18,   16'h8101, 16'h1234, 16'h0800, 48'h0102_0304_0506,
      48'hA1A2_A3A4_A5A6, 1'b0, STATUS_OK},
    '{12'd20,   16'h88A9, 16'h5678, 16'h86DD, 48'h00AA_55FF_0F0F,
      48'hF0F0_3C3C_C3C3, 1'b0, STATUS_OK},
    '{12'd14,   16'hFFFF, 16'h0000, 16'h0000, 48'h8000_0000_0001, 48'h7FFF_FFFF_FFFE,
      1'b0, STATUS_OK},
    '{12'd14,   16'h0000, 16'h0000, 16'h0000, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
      1'b0, STATUS_OK},
    '{12'd60,   16'h8100, 16'hE123, 16'h86DD, 48'h0123_4567_89AB, 48'hCDEF_0123_4567,
      1'b0, STATUS_OK}
  };

  ethernet_vlan_header_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Follows one accepted byte; returns 1 and the expected header at a frame end.
  function automatic logic parse_byte(input logic [7:0] d, input logic last,
                                      output evhp_result_t hdr);
    logic [CountWidth-1:0] pos;
    logic                  tag_seen;
    pos = byte_total;
    hdr = '0;
    if (pos < DstEnd) begin
      dst_acc = {dst_acc[39:0], d};
    end else if (pos < SrcEnd) begin
      src_acc = {src_acc[39:0], d};
    end else if (pos < TypeEnd) begin
      type_acc = {type_acc[7:0], d};
    end else if (pos < TagEnd) begin
      tci_acc = {tci_acc[7:0], d};
    end else if (pos < InnerEnd) begin
      inner_acc = {inner_acc[7:0], d};
    end
    if (pos != CountMax) byte_total = pos + 1'b1;
    if (!last) return 1'b0;

    tag_seen = (type_acc == TpidCtag) || (type_acc == TpidStag);
    if (byte_total < min_len || byte_total < TypeEnd) begin
      hdr.status = STATUS_TOO_SHORT;
    end else if (tag_seen && byte_total < TagEnd) begin
      hdr.status = STATUS_TRUNC_TAG;
    end else if (tag_seen && byte_total < InnerEnd) begin
      hdr.status = STATUS_TRUNC_INNER;
    end else begin
      hdr.status  = STATUS_OK;
      hdr.dst_mac = dst_acc;
      hdr.src_mac = src_acc;
      if (tag_seen) begin
        hdr.ethertype  = inner_acc;
        hdr.has_tag    = 1'b1;
        hdr.tag_tpid   = type_acc;
        hdr.tag_prio   = tci_acc[15:13];
        hdr.tag_vid    = tci_acc[11:0];
        hdr.header_len = HdrLenTagged;
      end else begin
        hdr.ethertype  = type_acc;
        hdr.header_len = HdrLenBase;
      end
    end
    byte_total = '0;
    dst_acc    = '0;
    src_acc    = '0;
    type_acc   = '0;
    tci_acc    = '0;
    inner_acc  = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Input and output monitor: feeds the predictor and checks every result.
  always @(posedge clk_i) begin
    evhp_result_t want;
    frame_mark_t  mark;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        if (parse_byte(s_data, s_last, want)) begin
          mark = frame_marks.pop_front();
          if (mark.typed) begin
            want        = '0;
            want.status = mark.status;
          end
          pending_headers.push_back(want);
        end
      end
      if (m_axis_tvalid_o && m_tready) begin
        if (pending_headers.size() == 0) begin
          $error("result transaction with no header expected");
          mismatches++;
        end else begin
          want = pending_headers.pop_front();
          check_field("status", 48'(want.status), 48'(m_axis_tuser_o));
          check_field("dst_mac", want.dst_mac, m_axis_tdata_o[47:0]);
          check_field("src_mac", want.src_mac, m_axis_tdata_o[95:48]);
          check_field("ethertype", 48'(want.ethertype), 48'(m_axis_tdata_o[111:96]));
          check_field("has_tag", 48'(want.has_tag), 48'(m_axis_tdata_o[112]));
          check_field("tag_tpid", 48'(want.tag_tpid), 48'(m_axis_tdata_o[128:113]));
          check_field("tag_prio", 48'(want.tag_prio), 48'(m_axis_tdata_o[131:129]));
          check_field("tag_vid", 48'(want.tag_vid), 48'(m_axis_tdata_o[143:132]));
          check_field("header_len", 48'(want.header_len), 48'(m_axis_tdata_o[148:144]));
          check_field("zero_fill", 48'h0, 48'(m_axis_tdata_o[151:149]));
        end
      end
    end
  end

  // Result side back-pressure; a long hold is loaded on request and counted here.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[ethernet_vlan_header_parser_core] ERROR");
      $finish;
    end
  end

  task automatic drive_byte(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < sender_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len, input logic [143:0] hdr,
                            input logic typed, input evhp_status_e status);
    logic [7:0] b;
    frame_marks.push_back('{typed, status});
    for (int unsigned i = 0; i < len; i++) begin
      b = (i < 18) ? hdr[143 - 8 * i -: 8] : 8'($urandom);
      drive_byte(b, i == len - 1);
    end
  endtask

  task automatic send_random_frame(input int unsigned len);
    logic [15:0] outer;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      outer = TpidCtag;
    end else if (pick < 65) begin
      outer = TpidStag;
    end else if (pick < 75) begin
      // One bit away from a tag protocol id must still parse as untagged.
      outer = ($urandom_range(1) ? TpidCtag : TpidStag) ^ (16'h1 << $urandom_range(15));
    end else begin
      outer = 16'($urandom);
    end
    send_frame(len, {16'($urandom), $urandom, 16'($urandom), $urandom, outer,
                     16'($urandom), 16'($urandom)}, 1'b0, STATUS_OK);
  endtask

  // Mostly complete headers, with truncated frames and lengths around the minimum.
  function automatic int unsigned pick_len();
    int unsigned pick;
    int          near;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1, 13);
    if (pick < 25) return $urandom_range(14, 17);
    if (pick < 45) begin
      near = int'(min_len) + int'($urandom_range(4)) - 2;
      return (near < 1) ? 1 : near;
    end
    if (pick < 90) return $urandom_range(18, 40);
    return $urandom_range(41, 80);
  endfunction

  // The sender pauses until every header has come back before the register moves.
  task automatic write_min_len(input logic [CfgWidth-1:0] value);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    min_len = value;
  endtask

  initial begin
    frame_row_t row;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle   = 36;
    receiver_idle = 70;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_frame(row.len, {row.dst, row.src, row.outer, row.tci, row.inner},
                 row.typed, row.status);
    end

    write_min_len(11'd0);
    repeat (3) send_random_frame(pick_len());

    sender_idle   = 70;
    receiver_idle = 36;
    write_min_len(11'd20);
    repeat (3) send_random_frame(pick_len());
    write_min_len(11'($urandom_range(21, 64)));
    repeat (3) send_random_frame(pick_len());

    sender_idle   = 0;
    receiver_idle = 0;
    // Lengths just below, at and above a raised minimum.
    write_min_len(11'd24);
    send_random_frame(23);
    send_random_frame(24);
    send_random_frame(25);
    send_random_frame(18);

    // Short frames against a stalled output fill the result slots and
    // push back on the byte stream.
    write_min_len(MinLenReset);
    hold_request = 400;
    repeat (12) send_random_frame($urandom_range(1, 3));
    repeat (2) send_random_frame(pick_len());

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ethernet_vlan_header_parser_core] OK");
    end else begin
      $display("[ethernet_vlan_header_parser_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/evhp_pkg.sv
rtl/core/evhp_capture.sv
rtl/core/evhp_result.sv
rtl/core/ethernet_vlan_header_parser_core.sv
sim/tb.sv
